// ----- hdl/multi_pattern_byte_scanner_macros.svh -----
// Assertion macros for the multi-pattern byte scanner.
// Used by the top level only; no other dependencies.
`ifndef MULTI_PATTERN_BYTE_SCANNER_MACROS_SVH
`define MULTI_PATTERN_BYTE_SCANNER_MACROS_SVH
// Implication checked on every edge outside reset.
`define MPBS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mpbs check failed");
// Next-cycle implication.
`define MPBS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mpbs check failed");
`endif

// ----- hdl/mpbs_pkg.sv -----
// Package for the multi-pattern byte scanner: sizes, table entry types.
// No dependencies.
`default_nettype none
package mpbs_pkg;
	localparam int NODE_COUNT = 4096;
	localparam int IDX_BITS = $clog2(NODE_COUNT);
	localparam int VALUE_BITS = 32;
	localparam int POSITION_BITS = 32;
	localparam int START_BITS = 33;
	localparam int DEPTH_BITS = IDX_BITS + 1;

	typedef logic [IDX_BITS-1:0] idx_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		idx_t parent;
		idx_t fail;
		logic [7:0] lchar;
		idx_t lchild;
		logic [7:0] rchar;
		idx_t rchild;
	} node_t;

	// memory port request from the walker
	typedef struct packed {
		logic we;
		idx_t addr;
		node_t wdata;
	} mem_req_t;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SCAN = 1'b1;
endpackage
`default_nettype wire

// ----- hdl/mpbs_node_ram.sv -----
// Node table memory: one port, synchronous read with the data registered in the cycle after the address.
// Depends on mpbs_pkg.
`default_nettype none
module mpbs_node_ram
	import mpbs_pkg::*;
(
	input wire logic clk,
	input mem_req_t req,
	output node_t rdata
);
	node_t mem [NODE_COUNT];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata <= mem[req.addr];
	end
endmodule
`default_nettype wire

// ----- hdl/mpbs_walker.sv -----
// Sequencer walking the node table: goto over sibling chain, fail links,
// parent chain for depth. Depends on mpbs_pkg.
`default_nettype none
module mpbs_walker
	import mpbs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic operation,
	input node_t wr_entry,
	input idx_t wr_index,
	input wire logic [7:0] scan_byte,
	input wire logic first_of_stream,
	output mem_req_t req,
	input node_t rdata,
	output logic res_valid,
	input wire logic res_ready,
	output logic [START_BITS-1:0] res_start,
	output logic [VALUE_BITS-1:0] res_value,
	output logic res_last
);
	typedef enum logic [3:0] {
		IDLE, RD_CUR, GOT_CUR, RD_SIB, GOT_SIB, RD_FAIL_P, GOT_FAIL_P,
		RD_NX, GOT_NX, RD_FL, GOT_FL, RD_UP, GOT_UP, EMIT
	} st_t;

	st_t st_q;
	idx_t cur_q, p_q, q_q, nx_q, fl_q, walk_q;
	logic [7:0] byte_q;
	logic [POSITION_BITS-1:0] pos_q, bpos_q;
	logic [IDX_BITS:0] n_q;
	logic [DEPTH_BITS-1:0] d_q;
	logic [VALUE_BITS-1:0] nxval_q, flval_q;
	logic two_q, second_q;
	logic [START_BITS-1:0] start_q;

	assign in_ready = (st_q == IDLE) && !res_valid;

	always_comb begin
		req = '0;
		req.wdata = wr_entry;
		unique case (st_q)
			IDLE: begin
				req.we = in_valid && in_ready && (operation == OP_LOAD);
				req.addr = wr_index;
			end
			RD_CUR: req.addr = p_q;
			RD_SIB: req.addr = q_q;
			RD_FAIL_P: req.addr = p_q;
			RD_NX: req.addr = nx_q;
			RD_FL: req.addr = fl_q;
			RD_UP: req.addr = walk_q;
			default: req.addr = p_q;
		endcase
	end

	// sequencer: accept a request, follow goto and fail links, then walk the parent chain of each nonzero target and emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			cur_q <= '0;
			bpos_q <= '0;
			res_valid <= 1'b0;
			res_last <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (res_valid && res_ready && st_q != EMIT) begin
				res_valid <= 1'b0;
			end
			unique case (st_q)
				IDLE: begin
					if (in_valid && in_ready && operation == OP_SCAN) begin
						p_q <= first_of_stream ? '0 : cur_q;
						pos_q <= first_of_stream ? '0 : bpos_q;
						bpos_q <= (first_of_stream ? '0 : bpos_q) + 1'b1;
						byte_q <= scan_byte;
						n_q <= '0;
						st_q <= RD_CUR;
					end
				end
				RD_CUR: st_q <= GOT_CUR;
				GOT_CUR: begin
					if (rdata.lchild == '0 || byte_q < rdata.lchar) begin
						st_q <= RD_FAIL_P;
					end else if (byte_q == rdata.lchar) begin
						nx_q <= rdata.lchild;
						st_q <= RD_NX;
					end else begin
						q_q <= rdata.lchild;
						d_q <= '0;
						st_q <= RD_SIB;
					end
				end
				RD_SIB: st_q <= GOT_SIB;
				GOT_SIB: begin
					// d_q counts sibling steps, capped at NODE_COUNT
					if (byte_q > rdata.rchar && rdata.rchild != '0
							&& d_q < DEPTH_BITS'(NODE_COUNT)) begin
						q_q <= rdata.rchild;
						d_q <= d_q + 1'b1;
						st_q <= RD_SIB;
					end else if (byte_q == rdata.rchar && rdata.rchild != '0) begin
						nx_q <= rdata.rchild;
						st_q <= RD_NX;
					end else begin
						st_q <= RD_FAIL_P;
					end
				end
				RD_FAIL_P: st_q <= GOT_FAIL_P;
				GOT_FAIL_P: begin
					if (rdata.fail == p_q || n_q >= (IDX_BITS+1)'(NODE_COUNT)) begin
						cur_q <= p_q;
						st_q <= IDLE;
					end else begin
						p_q <= rdata.fail;
						n_q <= n_q + 1'b1;
						st_q <= RD_CUR;
					end
				end
				RD_NX: st_q <= GOT_NX;
				GOT_NX: begin
					cur_q <= nx_q;
					nxval_q <= rdata.value;
					fl_q <= rdata.fail;
					if (rdata.value == '0) begin
						st_q <= IDLE;
					end else begin
						st_q <= RD_FL;
					end
				end
				RD_FL: st_q <= GOT_FL;
				GOT_FL: begin
					flval_q <= rdata.value;
					two_q <= (rdata.value != '0);
					second_q <= 1'b0;
					walk_q <= nx_q;
					d_q <= '0;
					st_q <= RD_UP;
				end
				RD_UP: st_q <= GOT_UP;
				GOT_UP: begin
					if (rdata.parent == walk_q || d_q == DEPTH_BITS'(NODE_COUNT)) begin
						start_q <= START_BITS'(pos_q) - START_BITS'(d_q);
						st_q <= EMIT;
					end else begin
						walk_q <= rdata.parent;
						d_q <= d_q + 1'b1;
						st_q <= RD_UP;
					end
				end
				EMIT: begin
					if (!res_valid || res_ready) begin
						res_valid <= 1'b1;
						res_start <= start_q;
						res_value <= second_q ? flval_q : nxval_q;
						res_last <= second_q || !two_q;
						if (two_q && !second_q) begin
							second_q <= 1'b1;
							walk_q <= fl_q;
							d_q <= '0;
							st_q <= RD_UP;
						end else begin
							st_q <= IDLE;
						end
					end
				end
				default: st_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hdl/multi_pattern_byte_scanner.sv -----
// Multi-pattern byte scanner: takes a load (table entry write) or a scan byte
// per request. Each scan walks the node table in a single-port RAM: it accepts
// the byte, reads the current node, then each sibling, per fail step reads the
// node again for its fail link and then the fail target, does a last fail check
// on a miss, reads the target and, if its value is nonzero, its fail node, reads
// each node on each match's parent chain (depth plus one reads) and presents
// each match; a load is written as it is accepted. No clearing pass: entries
// must be loaded before they are reached by a scan. Results go out one per
// output handshake, last marking the final match of a byte. Depends on
// mpbs_pkg, mpbs_node_ram, mpbs_walker and the assertion macro header.
`default_nettype none
`include "multi_pattern_byte_scanner_macros.svh"
module multi_pattern_byte_scanner
	import mpbs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic operation,
	input wire logic [11:0] node_index,
	input wire logic [31:0] node_value,
	input wire logic [11:0] parent_index,
	input wire logic [11:0] fail_index,
	input wire logic [7:0] left_char,
	input wire logic [11:0] left_child,
	input wire logic [7:0] right_char,
	input wire logic [11:0] right_child,
	input wire logic [7:0] scan_byte,
	input wire logic first_of_stream,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [32:0] match_start,
	output logic [31:0] match_value,
	output logic last
);
	mem_req_t req;
	node_t rdata, wr_entry;
	logic [START_BITS-1:0] res_start;

	assign wr_entry = '{value: node_value, parent: parent_index, fail: fail_index,
		lchar: left_char, lchild: left_child, rchar: right_char, rchild: right_child};

	mpbs_node_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

	mpbs_walker u_walk (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .wr_entry(wr_entry), .wr_index(node_index),
		.scan_byte(scan_byte), .first_of_stream(first_of_stream),
		.req(req), .rdata(rdata), .res_valid(out_valid), .res_ready(out_ready),
		.res_start(res_start), .res_value(match_value), .res_last(last)
	);

	assign match_start = $signed(res_start);

	// never accept while a result is pending
	`MPBS_ASSERT_IMP(a_no_accept_pending, out_valid, !in_ready)
	// a delivered non-last match is followed by more work, not idle acceptance
	`MPBS_ASSERT_NEXT(a_pair_follows, out_valid && out_ready && !last, !in_ready)
	// reported tags are never zero
	`MPBS_ASSERT_IMP(a_value_nonzero, out_valid, match_value != '0)
endmodule
`default_nettype wire

// ----- test/mpbs_scan_checker.sv -----
// Checker for the multi-pattern byte scanner: watches the request and result channels,
// predicts the matches of every scan and compares them in order.
// Depends on mpbs_pkg for the table sizes and the operation codes.
`timescale 1ns / 100ps
module mpbs_scan_checker
	import mpbs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic operation,
	input wire logic [11:0] node_index,
	input wire logic [31:0] node_value,
	input wire logic [11:0] parent_index,
	input wire logic [11:0] fail_index,
	input wire logic [7:0] left_char,
	input wire logic [11:0] left_child,
	input wire logic [7:0] right_char,
	input wire logic [11:0] right_child,
	input wire logic [7:0] scan_byte,
	input wire logic first_of_stream,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic signed [32:0] match_start,
	input wire logic [31:0] match_value,
	input wire logic last,
	output int errors,
	output int pending
);
	typedef struct packed {
		logic signed [32:0] start;
		logic [31:0] value;
		logic fin;
	} match_t;

	logic [31:0] tag_mem [NODE_COUNT];
	idx_t up_mem [NODE_COUNT];
	idx_t fb_mem [NODE_COUNT];
	idx_t kid_mem [NODE_COUNT];
	idx_t sib_mem [NODE_COUNT];
	logic [7:0] kid_chr [NODE_COUNT];
	logic [7:0] sib_chr [NODE_COUNT];
	idx_t cur_node;
	logic [31:0] byte_pos;
	match_t match_q [$];

	initial begin
		errors = 0;
		pending = 0;
	end

	// goto rule over the ascending sibling chain
	function automatic bit take_edge(input idx_t node, input logic [7:0] b, output idx_t dest);
		idx_t q;
		int n;
		dest = '0;
		n = 0;
		if (kid_mem[node] == 0 || b < kid_chr[node])
			return 0;
		if (b == kid_chr[node]) begin
			dest = kid_mem[node];
			return 1;
		end
		q = kid_mem[node];
		while (q != 0 && b > sib_chr[q] && n < NODE_COUNT) begin
			q = sib_mem[q];
			n++;
		end
		if (q != 0 && b == sib_chr[q] && sib_mem[q] != 0) begin
			dest = sib_mem[q];
			return 1;
		end
		return 0;
	endfunction

	function automatic logic [32:0] start_of(input idx_t node, input logic [31:0] p);
		idx_t s;
		int d;
		s = node;
		d = 0;
		while (up_mem[s] != s && d < NODE_COUNT) begin
			s = up_mem[s];
			d++;
		end
		return {1'b0, p} - 33'(d);
	endfunction

	always @(posedge clk) begin
		idx_t p;
		idx_t nx;
		idx_t fl;
		logic [31:0] pos;
		bit hit;
		int n;
		match_t got;
		match_t want;
		if (!arst_n) begin
			cur_node = '0;
			byte_pos = '0;
		end else begin
			if (in_valid && in_ready) begin
				if (operation == OP_LOAD) begin
					tag_mem[node_index] = node_value;
					up_mem[node_index] = parent_index;
					fb_mem[node_index] = fail_index;
					kid_chr[node_index] = left_char;
					kid_mem[node_index] = left_child;
					sib_chr[node_index] = right_char;
					sib_mem[node_index] = right_child;
				end else begin
					if (first_of_stream) begin
						cur_node = '0;
						byte_pos = '0;
					end
					pos = byte_pos;
					byte_pos = byte_pos + 32'd1;
					p = cur_node;
					hit = 0;
					n = 0;
					forever begin
						if (take_edge(p, scan_byte, nx)) begin
							hit = 1;
							break;
						end
						if (fb_mem[p] == p || n >= NODE_COUNT)
							break;
						p = fb_mem[p];
						n++;
					end
					if (!hit) begin
						cur_node = p;
					end else begin
						cur_node = nx;
						if (tag_mem[nx] != 0) begin
							fl = fb_mem[nx];
							if (tag_mem[fl] != 0) begin
								match_q.push_back('{start_of(nx, pos), tag_mem[nx], 1'b0});
								match_q.push_back('{start_of(fl, pos), tag_mem[fl], 1'b1});
							end else begin
								match_q.push_back('{start_of(nx, pos), tag_mem[nx], 1'b1});
							end
						end
					end
				end
			end
			if (out_valid && out_ready) begin
				got = '{match_start, match_value, last};
				if (match_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected match start=%0d value=%h last=%b",
						$realtime, got.start, got.value, got.fin);
				end else begin
					want = match_q.pop_front();
					if (got.start !== want.start) begin
						errors++;
						$display("%0t: match_start expected %0d got %0d",
							$realtime, want.start, got.start);
					end
					if (got.value !== want.value) begin
						errors++;
						$display("%0t: match_value expected %h got %h",
							$realtime, want.value, got.value);
					end
					if (got.fin !== want.fin) begin
						errors++;
						$display("%0t: last expected %b got %b",
							$realtime, want.fin, got.fin);
					end
				end
			end
		end
		pending = match_q.size();
	end
endmodule

// ----- test/tb_multi_pattern_byte_scanner.sv -----
// Testbench top for the multi-pattern byte scanner: loads tries (sound and
// deliberately broken), scans text over them and gives the verdict.
// Depends on mpbs_pkg, the scanner RTL and mpbs_scan_checker.
`timescale 1ns / 100ps
module tb_multi_pattern_byte_scanner;
	import mpbs_pkg::*;

	typedef struct {
		logic op;
		logic [11:0] idx;
		logic [31:0] val;
		logic [11:0] par;
		logic [11:0] fl;
		logic [7:0] lc;
		logic [11:0] lk;
		logic [7:0] rc;
		logic [11:0] rk;
		logic [7:0] sb;
		logic fs;
	} req_t;

	localparam int MAXN = 40;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic operation = 0;
	logic [11:0] node_index = 0;
	logic [31:0] node_value = 0;
	logic [11:0] parent_index = 0;
	logic [11:0] fail_index = 0;
	logic [7:0] left_char = 0;
	logic [11:0] left_child = 0;
	logic [7:0] right_char = 0;
	logic [11:0] right_child = 0;
	logic [7:0] scan_byte = 0;
	logic first_of_stream = 0;
	logic out_ready = 0;
	logic in_ready;
	logic out_valid;
	logic signed [32:0] match_start;
	logic [31:0] match_value;
	logic last;
	int errors;
	int pending;

	logic in_took = 0;
	logic out_took = 0;
	bit quiet = 0;
	int items_sent = 0;

	// trie under construction: node 0 is the root
	int tn;
	logic [7:0] tch [MAXN];
	int tpar [MAXN];
	int tdep [MAXN];
	int tfail [MAXN];
	logic [31:0] tval [MAXN];
	idx_t tphys [MAXN];
	bit used [NODE_COUNT];
	logic [7:0] pat [8][4];
	int plen [8];
	logic [31:0] pval [8];
	int np;
	logic [7:0] alph [4];
	logic [31:0] root_val;

	multi_pattern_byte_scanner uut (.*);

	mpbs_scan_checker chk (.*);

	always begin
		clk = 1;
		#5;
		clk = 0;
		#5;
	end

	always @(posedge clk) begin
		in_took <= in_valid && in_ready;
		out_took <= out_valid && out_ready;
	end

	// broken tables can force full-length parent walks on every scan
	initial begin
		#1s;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_req(input req_t r);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		operation <= r.op;
		node_index <= r.idx;
		node_value <= r.val;
		parent_index <= r.par;
		fail_index <= r.fl;
		left_char <= r.lc;
		left_child <= r.lk;
		right_char <= r.rc;
		right_child <= r.rk;
		scan_byte <= r.sb;
		first_of_stream <= r.fs;
		in_valid <= 1;
		do @(negedge clk); while (!in_took);
		items_sent++;
	endtask

	function automatic req_t noise_req();
		req_t r;
		r = '{1'($urandom), 12'($urandom), $urandom, 12'($urandom), 12'($urandom),
			8'($urandom), 12'($urandom), 8'($urandom), 12'($urandom), 8'($urandom),
			1'($urandom)};
		return r;
	endfunction

	task automatic load_node(input idx_t at, input logic [31:0] v, input idx_t par,
			input idx_t fl, input logic [7:0] lc, input idx_t lk,
			input logic [7:0] rc, input idx_t rk);
		req_t r;
		r = noise_req();
		r.op = OP_LOAD;
		r.idx = at;
		r.val = v;
		r.par = par;
		r.fl = fl;
		r.lc = lc;
		r.lk = lk;
		r.rc = rc;
		r.rk = rk;
		send_req(r);
	endtask

	task automatic scan(input logic [7:0] b, input logic fs);
		req_t r;
		r = noise_req();
		r.op = OP_SCAN;
		r.sb = b;
		r.fs = fs;
		send_req(r);
	endtask

	function automatic int kid_of(input int n, input logic [7:0] c);
		for (int k = 1; k < tn; k++)
			if (tpar[k] == n && tch[k] == c)
				return k;
		return -1;
	endfunction

	function automatic idx_t fresh_index();
		int x;
		do x = $urandom_range(1, NODE_COUNT - 1); while (used[x]);
		used[x] = 1;
		return idx_t'(x);
	endfunction

	// builds the trie from pat/plen/pval, computes fail links, loads every node
	task automatic build_and_load(input bit high_idx);
		int cur;
		int k;
		int g;
		int f;
		int fk;
		int nk;
		for (int i = 0; i < NODE_COUNT; i++)
			used[i] = 0;
		tn = 1;
		tpar[0] = 0;
		tdep[0] = 0;
		tval[0] = root_val;
		for (int p = 0; p < np; p++) begin
			cur = 0;
			for (int i = 0; i < plen[p]; i++) begin
				k = kid_of(cur, pat[p][i]);
				if (k < 0) begin
					k = tn++;
					tch[k] = pat[p][i];
					tpar[k] = cur;
					tdep[k] = tdep[cur] + 1;
					tval[k] = 0;
				end
				cur = k;
			end
			tval[cur] = pval[p];
		end
		tfail[0] = 0;
		for (int d = 1; d <= 4; d++)
			for (k = 1; k < tn; k++)
				if (tdep[k] == d) begin
					if (d == 1) begin
						tfail[k] = 0;
					end else begin
						f = tfail[tpar[k]];
						forever begin
							g = kid_of(f, tch[k]);
							if (g >= 0) begin
								tfail[k] = g;
								break;
							end
							if (f == 0) begin
								tfail[k] = 0;
								break;
							end
							f = tfail[f];
						end
					end
				end
		tphys[0] = 0;
		for (k = 1; k < tn; k++)
			tphys[k] = high_idx ? idx_t'(NODE_COUNT - k) : fresh_index();
		for (k = 0; k < tn; k++) begin
			fk = -1;
			nk = -1;
			for (int j = 1; j < tn; j++) begin
				if (tpar[j] == k && (fk < 0 || tch[j] < tch[fk]))
					fk = j;
				if (k > 0 && j != k && tpar[j] == tpar[k] && tch[j] > tch[k]
						&& (nk < 0 || tch[j] < tch[nk]))
					nk = j;
			end
			load_node(tphys[k], tval[k], tphys[tpar[k]], tphys[tfail[k]],
				fk < 0 ? 8'($urandom) : tch[fk], fk < 0 ? idx_t'(0) : tphys[fk],
				nk < 0 ? 8'($urandom) : tch[nk], nk < 0 ? idx_t'(0) : tphys[nk]);
		end
	endtask

	task automatic run_text(input int n);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			b = ($urandom_range(0, 6) != 0) ? alph[$urandom_range(0, 3)] : 8'($urandom);
			scan(b, i == 0 || $urandom_range(0, 29) == 0);
		end
	endtask

	// small table with odd links: self fail links off the root, parent loops,
	// siblings only toward later entries so chains stay finite
	task automatic broken_phase();
		int cnt;
		idx_t s [8];
		idx_t par;
		idx_t fl;
		idx_t lk;
		idx_t rk;
		for (int i = 0; i < NODE_COUNT; i++)
			used[i] = 0;
		cnt = $urandom_range(3, 8);
		s[0] = 0;
		for (int i = 1; i < cnt; i++)
			s[i] = fresh_index();
		for (int i = 0; i < cnt; i++) begin
			if (i == 0)
				par = 0;
			else if ($urandom_range(0, 7) == 0)
				par = s[$urandom_range(0, cnt - 1)];
			else if ($urandom_range(0, 3) == 0)
				par = s[i];
			else
				par = s[$urandom_range(0, i - 1)];
			if (i == 0 || $urandom_range(0, 5) == 0)
				fl = s[i];
			else
				fl = s[$urandom_range(0, i - 1)];
			lk = ($urandom_range(0, 3) == 0) ? idx_t'(0) : s[$urandom_range(0, cnt - 1)];
			rk = (i == cnt - 1 || $urandom_range(0, 2) == 0) ? idx_t'(0)
				: s[$urandom_range(i + 1, cnt - 1)];
			load_node(s[i], $urandom_range(0, 1) ? $urandom : 32'd0, par, fl,
				alph[$urandom_range(0, 3)], lk, alph[$urandom_range(0, 3)], rk);
		end
		run_text(30);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		fork
			forever begin
				int stall;
				stall = quiet ? 0 : $urandom_range(0, 9);
				if (stall > 0) begin
					out_ready <= 0;
					repeat (stall) @(negedge clk);
				end
				out_ready <= 1;
				do @(negedge clk); while (!out_took);
			end
		join_none

		// directed: extreme bytes, extreme tags, top indices, double match
		np = 3;
		root_val = 0;
		pat[0][0] = 8'h00;
		pat[0][1] = 8'hFF;
		plen[0] = 2;
		pval[0] = 32'hFFFF_FFFF;
		pat[1][0] = 8'hFF;
		plen[1] = 1;
		pval[1] = 32'h0000_0001;
		pat[2][0] = 8'h00;
		plen[2] = 1;
		pval[2] = 32'h8000_0000;
		build_and_load(1);
		scan(8'h00, 1);
		scan(8'hFF, 0);
		scan(8'hFF, 0);
		scan(8'h7A, 0);
		scan(8'h00, 0);
		scan(8'h00, 0);
		scan(8'hFF, 0);
		scan(8'h00, 1);
		scan(8'hFF, 0);
		scan(8'h80, 0);

		while (items_sent < 750) begin
			quiet = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 4; i++)
				alph[i] = 8'($urandom);
			if ($urandom_range(0, 4) == 0) begin
				broken_phase();
			end else begin
				np = $urandom_range(2, 6);
				root_val = ($urandom_range(0, 5) == 0) ? $urandom : 32'd0;
				for (int p = 0; p < np; p++) begin
					plen[p] = $urandom_range(1, 4);
					for (int i = 0; i < 4; i++)
						pat[p][i] = alph[$urandom_range(0, 3)];
					pval[p] = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
				end
				build_and_load(0);
				run_text($urandom_range(40, 100));
			end
		end
		in_valid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
